// ----- rtl/mrpf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpf_pkg
// Shared widths, constants and result codes of the primality classifier.
// ----------------------------------------------------------------------------
package mrpf_pkg;

  localparam int NUMBER_WIDTH = 62;
  localparam int GW           = 64;  // gcd datapath, wide enough for the prime products

  localparam logic [1:0] VERDICT_PRIME     = 2'd0;
  localparam logic [1:0] VERDICT_NOT_PRIME = 2'd1;
  localparam logic [1:0] VERDICT_FACTOR    = 2'd2;

  // bit i set when i is a prime below 64
  localparam logic [63:0] TINY_PRIME_MASK = 64'h28208A20_A08A28AC;

  localparam logic [NUMBER_WIDTH-1:0] SPLIT_POINT = NUMBER_WIDTH'(64'd1 << 30);

  localparam logic [GW-1:0] PROD_SMALL = 64'd3 * 64'd5 * 64'd7 * 64'd11 * 64'd13 *
                                         64'd17 * 64'd19 * 64'd23 * 64'd29;
  localparam logic [GW-1:0] PROD_LARGE = 64'd3 * 64'd5 * 64'd7 * 64'd11 * 64'd13 *
                                         64'd17 * 64'd19 * 64'd23 * 64'd29 * 64'd31 *
                                         64'd37 * 64'd41 * 64'd43 * 64'd47 * 64'd53;

  localparam int BASE_BITS = 31;

  function automatic logic [BASE_BITS-1:0] base_at(input logic use_small,
                                                   input logic [2:0] idx);
    logic [BASE_BITS-1:0] b;
    b = 31'd2;
    if (use_small) begin
      case (idx)
        3'd0:    b = 31'd2;
        3'd1:    b = 31'd7;
        3'd2:    b = 31'd61;
        default: b = 31'd2;
      endcase
    end else begin
      case (idx)
        3'd0:    b = 31'd2;
        3'd1:    b = 31'd325;
        3'd2:    b = 31'd9375;
        3'd3:    b = 31'd28178;
        3'd4:    b = 31'd450775;
        3'd5:    b = 31'd9780504;
        3'd6:    b = 31'd1795265022;
        default: b = 31'd2;
      endcase
    end
    return b;
  endfunction

endpackage

// ----- rtl/mrpf_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpf_in_if
// Input channel: one integer to classify per transfer.
// ----------------------------------------------------------------------------
interface mrpf_in_if import mrpf_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [NUMBER_WIDTH-1:0] number_in;

  modport source (output valid, output number_in, input ready);
  modport sink   (input valid, input number_in, output ready);
endinterface

// ----- rtl/mrpf_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpf_out_if
// Result channel: verdict and factor, one transfer per input integer.
// ----------------------------------------------------------------------------
interface mrpf_out_if import mrpf_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [1:0]              verdict;
  logic [NUMBER_WIDTH-1:0] found_factor;

  modport source (output valid, output verdict, output found_factor, input ready);
  modport sink   (input valid, input verdict, input found_factor, output ready);
endinterface

// ----- rtl/miller_rabin_prime_or_factor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// miller_rabin_prime_or_factor
// Classifies an integer below 2^62 as prime, composite, or gives a factor,
// using small-prime gcd screening and deterministic Miller-Rabin.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  in_ch     in   valid/ready        number_in[61:0]
//  out_ch    out  valid/ready        verdict[1:0], found_factor[61:0]
//
//  numbers below 64 and even numbers skip the gcd and Miller-Rabin steps
//  others: binary gcd, then per base up to ~124 modular products on the
//  bit-serial add-and-double unit; the worst-case run time is set by that one
//  shared unit
//  one number at a time: in_ch.ready is high only when idle
//  result held in an output register until transferred; reset is synchronous
// ----------------------------------------------------------------------------
module miller_rabin_prime_or_factor import mrpf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  mrpf_in_if.sink     in_ch,
  mrpf_out_if.source  out_ch
);

  localparam int NW = NUMBER_WIDTH;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_GCD   = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_BASE  = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_BRED  = 4'd5;
  localparam logic [3:0] S_PSTEP = 4'd6;
  localparam logic [3:0] S_PACC  = 4'd7;
  localparam logic [3:0] S_PSQ   = 4'd8;
  localparam logic [3:0] S_CHK   = 4'd9;
  localparam logic [3:0] S_SQSTP = 4'd10;
  localparam logic [3:0] S_SQRES = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  logic [3:0]    state_r, state_nxt, ret_r, ret_nxt;
  logic [NW-1:0] n_r, n_nxt, d_r, d_nxt;
  logic [5:0]    r_r, r_nxt, rc_r, rc_nxt;
  logic [2:0]    bi_r, bi_nxt;
  logic          small_r, small_nxt, gret_r, gret_nxt;
  logic [NW-1:0] ma_r, ma_nxt, mb_r, mb_nxt, macc_r, macc_nxt;
  logic [NW-1:0] pe_r, pe_nxt, pacc_r, pacc_nxt, pbase_r, pbase_nxt;
  logic [GW-1:0] ga_r, ga_nxt, gb_r, gb_nxt;
  logic [1:0]    rv_r, rv_nxt;
  logic [NW-1:0] rf_r, rf_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_verdict_r, out_verdict_nxt;
  logic [NW-1:0] out_factor_r, out_factor_nxt;

  logic [NW-1:0] m1;
  logic [NW:0]   acc_sum, acc_red, dbl_sum, dbl_red;
  logic          last_base;

  assign m1 = n_r - NW'(1);

  // add-and-double step of the shared modular multiplier
  assign acc_sum = {1'b0, macc_r} + {1'b0, ma_r};
  assign acc_red = (acc_sum >= {1'b0, n_r}) ? acc_sum - {1'b0, n_r} : acc_sum;
  assign dbl_sum = {ma_r, 1'b0};
  assign dbl_red = (dbl_sum >= {1'b0, n_r}) ? dbl_sum - {1'b0, n_r} : dbl_sum;

  assign last_base = small_r ? (bi_r == 3'd2) : (bi_r == 3'd6);

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.verdict      = out_verdict_r;
  assign out_ch.found_factor = out_factor_r;

  always_comb begin
    state_nxt = state_r;  ret_nxt = ret_r;
    n_nxt = n_r;  d_nxt = d_r;  r_nxt = r_r;  rc_nxt = rc_r;  bi_nxt = bi_r;
    small_nxt = small_r;  gret_nxt = gret_r;
    ma_nxt = ma_r;  mb_nxt = mb_r;  macc_nxt = macc_r;
    pe_nxt = pe_r;  pacc_nxt = pacc_r;  pbase_nxt = pbase_r;
    ga_nxt = ga_r;  gb_nxt = gb_r;
    rv_nxt = rv_r;  rf_nxt = rf_r;
    out_verdict_nxt = out_verdict_r;  out_factor_nxt = out_factor_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          n_nxt  = in_ch.number_in;
          rf_nxt = '0;
          if (in_ch.number_in < NW'(64)) begin
            rv_nxt    = TINY_PRIME_MASK[in_ch.number_in[5:0]] ? VERDICT_PRIME
                                                             : VERDICT_NOT_PRIME;
            state_nxt = S_FIN;
          end else if (!in_ch.number_in[0]) begin
            rv_nxt    = VERDICT_FACTOR;
            rf_nxt    = NW'(2);
            state_nxt = S_FIN;
          end else begin
            small_nxt = (in_ch.number_in < SPLIT_POINT);
            ga_nxt    = {{(GW-NW){1'b0}}, in_ch.number_in};
            gb_nxt    = (in_ch.number_in < SPLIT_POINT) ? PROD_SMALL : PROD_LARGE;
            gret_nxt  = 1'b0;
            state_nxt = S_GCD;
          end
        end
      end
      // binary gcd, one step a cycle; n is odd so no common power of two
      S_GCD: begin
        if (gb_r == '0) begin
          if (!gret_r) begin
            if (ga_r != GW'(1)) begin
              if (ga_r != {{(GW-NW){1'b0}}, n_r}) begin
                rv_nxt = VERDICT_FACTOR;
                rf_nxt = ga_r[NW-1:0];
              end else begin
                rv_nxt = VERDICT_NOT_PRIME;
              end
              state_nxt = S_FIN;
            end else begin
              d_nxt     = m1;
              r_nxt     = '0;
              state_nxt = S_DEC;
            end
          end else if (ga_r == GW'(1)) begin
            if (last_base) begin
              rv_nxt    = VERDICT_PRIME;
              state_nxt = S_FIN;
            end else begin
              bi_nxt    = bi_r + 3'd1;
              state_nxt = S_BASE;
            end
          end else begin
            if (ga_r < {{(GW-NW){1'b0}}, n_r}) begin
              rv_nxt = VERDICT_FACTOR;
              rf_nxt = ga_r[NW-1:0];
            end else begin
              rv_nxt = VERDICT_NOT_PRIME;
            end
            state_nxt = S_FIN;
          end
        end else if (!ga_r[0]) begin
          ga_nxt = ga_r >> 1;
        end else if (!gb_r[0]) begin
          gb_nxt = gb_r >> 1;
        end else if (ga_r > gb_r) begin
          ga_nxt = gb_r;
          gb_nxt = ga_r - gb_r;
        end else begin
          gb_nxt = gb_r - ga_r;
        end
      end
      S_DEC: begin
        if (!d_r[0]) begin
          d_nxt = d_r >> 1;
          r_nxt = r_r + 6'd1;
        end else begin
          bi_nxt    = '0;
          state_nxt = S_BASE;
        end
      end
      // reduce the base mod n as the product 1 * base
      S_BASE: begin
        ma_nxt    = NW'(1);
        mb_nxt    = {{(NW-BASE_BITS){1'b0}}, base_at(small_r, bi_r)};
        macc_nxt  = '0;
        ret_nxt   = S_BRED;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (mb_r == '0) begin
          state_nxt = ret_r;
        end else begin
          if (mb_r[0]) macc_nxt = acc_red[NW-1:0];
          ma_nxt = dbl_red[NW-1:0];
          mb_nxt = mb_r >> 1;
        end
      end
      S_BRED: begin
        pbase_nxt = macc_r;
        pacc_nxt  = NW'(1);
        pe_nxt    = d_r;
        state_nxt = S_PSTEP;
      end
      S_PSTEP: begin
        macc_nxt = '0;
        if (pe_r == '0) begin
          state_nxt = S_CHK;
        end else if (pe_r[0]) begin
          ma_nxt    = pacc_r;
          mb_nxt    = pbase_r;
          ret_nxt   = S_PACC;
          state_nxt = S_MUL;
        end else begin
          ma_nxt    = pbase_r;
          mb_nxt    = pbase_r;
          ret_nxt   = S_PSQ;
          state_nxt = S_MUL;
        end
      end
      S_PACC: begin
        pacc_nxt  = macc_r;
        ma_nxt    = pbase_r;
        mb_nxt    = pbase_r;
        macc_nxt  = '0;
        ret_nxt   = S_PSQ;
        state_nxt = S_MUL;
      end
      S_PSQ: begin
        pbase_nxt = macc_r;
        pe_nxt    = pe_r >> 1;
        state_nxt = S_PSTEP;
      end
      S_CHK: begin
        if (pacc_r == NW'(1) || pacc_r == m1) begin
          if (last_base) begin
            rv_nxt    = VERDICT_PRIME;
            state_nxt = S_FIN;
          end else begin
            bi_nxt    = bi_r + 3'd1;
            state_nxt = S_BASE;
          end
        end else begin
          rc_nxt    = r_r;
          state_nxt = S_SQSTP;
        end
      end
      S_SQSTP: begin
        if (rc_r == '0) begin
          rv_nxt    = VERDICT_NOT_PRIME;
          state_nxt = S_FIN;
        end else begin
          ma_nxt    = pacc_r;
          mb_nxt    = pacc_r;
          macc_nxt  = '0;
          ret_nxt   = S_SQRES;
          state_nxt = S_MUL;
        end
      end
      S_SQRES: begin
        if (macc_r == NW'(1)) begin
          // nontrivial square root of one
          ga_nxt    = {{(GW-NW){1'b0}}, (pacc_r == '0) ? m1 : pacc_r - NW'(1)};
          gb_nxt    = {{(GW-NW){1'b0}}, n_r};
          gret_nxt  = 1'b1;
          state_nxt = S_GCD;
        end else begin
          pacc_nxt = macc_r;
          rc_nxt   = rc_r - 6'd1;
          if (macc_r == m1) begin
            if (last_base) begin
              rv_nxt    = VERDICT_PRIME;
              state_nxt = S_FIN;
            end else begin
              bi_nxt    = bi_r + 3'd1;
              state_nxt = S_BASE;
            end
          end else begin
            state_nxt = S_SQSTP;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          out_verdict_nxt = rv_r;
          out_factor_nxt  = rf_r;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r <= ret_nxt;  n_r <= n_nxt;  d_r <= d_nxt;  r_r <= r_nxt;  rc_r <= rc_nxt;
    bi_r <= bi_nxt;  small_r <= small_nxt;  gret_r <= gret_nxt;
    ma_r <= ma_nxt;  mb_r <= mb_nxt;  macc_r <= macc_nxt;
    pe_r <= pe_nxt;  pacc_r <= pacc_nxt;  pbase_r <= pbase_nxt;
    ga_r <= ga_nxt;  gb_r <= gb_nxt;  rv_r <= rv_nxt;  rf_r <= rf_nxt;
    out_verdict_r <= out_verdict_nxt;  out_factor_r <= out_factor_nxt;
  end

  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_verdict_r != 2'd3))
    else $error("illegal verdict code");

  a_factor_only_with_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_verdict_r != VERDICT_FACTOR) |-> (out_factor_r == '0))
    else $error("factor reported without factor verdict");

  a_mul_operand_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (ma_r < n_r && macc_r < n_r))
    else $error("multiplier operand not reduced");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("accepted a second number while busy");

endmodule
